FILE: hw/rtl/button_debounce_press_timer_macros.svh
// Assertion macros shared by the verification files of the button debouncer.
`ifndef BUTTON_DEBOUNCE_PRESS_TIMER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_TIMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bdpt_pkg.sv
// Package with the transaction types and fixed constants of the button debouncer.
`timescale 1ns / 1ps
`default_nettype none

package bdpt_pkg;

  localparam int unsigned StampWidth  = 32;
  localparam int unsigned WindowWidth = 16;
  localparam logic [WindowWidth-1:0] WindowResetMs = 16'd50;

  typedef struct packed {
    logic                  raw_level;
    logic [StampWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  still_debouncing;
    logic                  pressed_pulse;
    logic                  released_pulse;
    logic [StampWidth-1:0] press_duration_ms;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/button_debounce_press_timer.sv
// Top level of the button debouncer with press-duration timer.
// Each accepted transaction carries one raw active-low button sample and the current
// millisecond timestamp, and yields exactly one result transaction. The block takes one
// sample per clock cycle while the output is not stalled. An accepted sample is held in
// the input register and then evaluated into the result register, which offers it on the
// output; the debouncer state is updated along with the result register and feeds the next
// sample. A result that waits on a stalled output still lets one further sample enter the
// input register. Timestamps are kept modulo 2^TIME_WIDTH; the debounce window is to be
// written through the configuration port while the block is idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_timer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bdpt_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bdpt_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bdpt_pkg::WindowWidth-1:0] cfg_wdata_i
);

  logic                             in_valid_q;
  bdpt_pkg::in_item_t               in_data_q;
  logic                             out_valid_q;
  bdpt_pkg::out_item_t              out_data_q;
  logic [bdpt_pkg::WindowWidth-1:0] window_q;

  logic                  raw_seen_q, raw_seen_d;
  logic                  steady_q, steady_d;
  logic [TIME_WIDTH-1:0] last_change_q, last_change_d;
  logic [TIME_WIDTH-1:0] press_time_q, press_time_d;
  logic [TIME_WIDTH-1:0] release_time_q, release_time_d;
  bdpt_pkg::out_item_t   result_d;

  logic eval_fire;
  logic in_fire;

  assign eval_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || eval_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  bdpt_eval #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_eval (
    .item_i         (in_data_q),
    .window_i       (window_q),
    .raw_seen_i     (raw_seen_q),
    .steady_i       (steady_q),
    .last_change_i  (last_change_q),
    .press_time_i   (press_time_q),
    .release_time_i (release_time_q),
    .raw_seen_o     (raw_seen_d),
    .steady_o       (steady_d),
    .last_change_o  (last_change_d),
    .press_time_o   (press_time_d),
    .release_time_o (release_time_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      window_q       <= bdpt_pkg::WindowResetMs;
      raw_seen_q     <= 1'b1;
      steady_q       <= 1'b1;
      last_change_q  <= '0;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (eval_fire) begin
        in_valid_q <= 1'b0;
      end
      if (eval_fire) begin
        out_valid_q    <= 1'b1;
        raw_seen_q     <= raw_seen_d;
        steady_q       <= steady_d;
        last_change_q  <= last_change_d;
        press_time_q   <= press_time_d;
        release_time_q <= release_time_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
    if (eval_fire) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bdpt_eval.sv
// Combinational evaluation of one sample: next debouncer state and the result.
`timescale 1ns / 1ps
`default_nettype none

module bdpt_eval #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  bdpt_pkg::in_item_t                    item_i,
  input  logic [bdpt_pkg::WindowWidth-1:0]      window_i,
  input  logic                                  raw_seen_i,
  input  logic                                  steady_i,
  input  logic [TIME_WIDTH-1:0]                 last_change_i,
  input  logic [TIME_WIDTH-1:0]                 press_time_i,
  input  logic [TIME_WIDTH-1:0]                 release_time_i,
  output logic                                  raw_seen_o,
  output logic                                  steady_o,
  output logic [TIME_WIDTH-1:0]                 last_change_o,
  output logic [TIME_WIDTH-1:0]                 press_time_o,
  output logic [TIME_WIDTH-1:0]                 release_time_o,
  output bdpt_pkg::out_item_t                   result_o
);

  logic [63:0]           now_wide;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [63:0]           elapsed_wide;
  logic [63:0]           window_wide;
  logic [TIME_WIDTH-1:0] duration;
  logic [63:0]           duration_wide;
  logic                  level;
  logic                  busy;
  logic                  confirm;

  assign level    = item_i.raw_level;
  assign now_wide = {{(64 - bdpt_pkg::StampWidth){1'b0}}, item_i.now_ms};
  assign now_t    = now_wide[TIME_WIDTH-1:0];

  assign raw_seen_o    = level;
  assign last_change_o = (level != raw_seen_i) ? now_t : last_change_i;

  assign elapsed      = now_t - last_change_o;
  assign elapsed_wide = {{(64 - TIME_WIDTH){1'b0}}, elapsed};
  assign window_wide  = {{(64 - bdpt_pkg::WindowWidth){1'b0}}, window_i};
  assign busy         = elapsed_wide < window_wide;

  assign confirm        = !busy && (steady_i != level);
  assign steady_o       = confirm ? level : steady_i;
  assign press_time_o   = (confirm && !level) ? now_t : press_time_i;
  assign release_time_o = (confirm && level) ? now_t : release_time_i;

  assign duration      = release_time_o - press_time_o;
  assign duration_wide = {{(64 - TIME_WIDTH){1'b0}}, duration};

  assign result_o.still_debouncing  = busy;
  assign result_o.pressed_pulse     = confirm && !level;
  assign result_o.released_pulse    = confirm && level;
  assign result_o.press_duration_ms = duration_wide[bdpt_pkg::StampWidth-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/bdpt_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_press_timer_macros.svh"

module bdpt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input bdpt_pkg::in_item_t               in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input bdpt_pkg::out_item_t              out_data_o
);

  `BDPT_ASSERT_SAME(a_single_pulse, clk_i, rst_ni, out_valid_o, !(out_data_o.pressed_pulse && out_data_o.released_pulse), "Both pulses are set in one result.")

  `BDPT_ASSERT_SAME(a_no_pulse_busy, clk_i, rst_ni, out_valid_o && out_data_o.still_debouncing, !out_data_o.pressed_pulse && !out_data_o.released_pulse, "A pulse is reported while still debouncing.")

  `BDPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "A stalled result transaction changed.")

  `BDPT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i), "A stalled input transaction changed.")

endmodule

bind button_debounce_press_timer bdpt_checker u_bdpt_checker (.*);

`default_nettype wire
